### rtl/abtf_pkg.sv
// shared types and constants of the alpha-beta track filter
`timescale 1ns / 1ps
package abtf_pkg;

  typedef struct packed {
    logic        [15:0] observer_id;
    logic        [15:0] target_id;
    logic        [31:0] obs_time;
    logic signed [31:0] meas_pos_x;
    logic signed [31:0] meas_pos_y;
    logic signed [31:0] meas_pos_z;
    logic signed [31:0] meas_vel_x;
    logic signed [31:0] meas_vel_y;
    logic signed [31:0] meas_vel_z;
    logic        [15:0] meas_confidence;
  } obs_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] est_pos_x;
    logic signed [31:0] est_pos_y;
    logic signed [31:0] est_pos_z;
    logic signed [31:0] est_vel_x;
    logic signed [31:0] est_vel_y;
    logic signed [31:0] est_vel_z;
    logic        [15:0] est_confidence;
    logic        [15:0] update_count;
  } res_t;

  typedef struct packed {
    logic [31:0]      key;
    logic [31:0]      time_tag;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] acc;
    logic [15:0]      conf;
    logic [15:0]      count;
  } entry_t;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd1,
    ALU_DIV = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_SAME     = 3'd1;
  localparam logic [2:0] ST_FILTERED = 3'd2;
  localparam logic [2:0] ST_BAD_ID   = 3'd3;
  localparam logic [2:0] ST_STALE    = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [15:0] CONF_ONE    = 16'd32768;
  localparam logic [15:0] ALPHA_BASE  = 16'd13107;
  localparam logic [15:0] ALPHA_SLOPE = 16'd49152;
  localparam logic [15:0] BETA_BASE   = 16'd3277;
  localparam logic [15:0] BETA_SLOPE  = 16'd36045;
  localparam logic [15:0] VW_BASE     = 16'd16384;
  localparam logic [15:0] VW_SLOPE    = 16'd42598;
  localparam logic [15:0] CONF_KEEP   = 16'd18022;
  localparam logic [15:0] CONF_NEW    = 16'd14746;
  localparam logic [39:0] WIDE_LIM    = 40'hFF_FFFF_FFFF;

endpackage

### rtl/abtf_alu.sv
// shared multiply and divide unit: 64x64 multiply from 32x32 partial products, 64/32 divide
`timescale 1ns / 1ps
module abtf_alu (
  input  logic               clk,
  input  logic               rst,
  input  abtf_pkg::alu_cmd_t cmd,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  output logic               done,
  output logic [127:0]       res
);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_MUL  = 3'b010,
    A_DIV  = 3'b100
  } alu_state_t;

  alu_state_t   state;
  logic [6:0]   cnt;
  logic [63:0]  op_a;
  logic [63:0]  op_b;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic         pp_vld;
  logic [127:0] acc;
  logic [31:0]  rem;
  logic [63:0]  quo;
  logic [31:0]  half_a;
  logic [31:0]  half_b;
  logic [127:0] pp_ext;
  logic [32:0]  trial;
  logic         qbit;

  assign res = acc;

  always_comb begin
    half_a = cnt[1] ? op_a[63:32] : op_a[31:0];
    half_b = cnt[0] ? op_b[63:32] : op_b[31:0];
    case (pp_sh)
      2'd0:    pp_ext = {64'b0, pp};
      2'd1:    pp_ext = {32'b0, pp, 32'b0};
      2'd2:    pp_ext = {pp, 64'b0};
      default: pp_ext = '0;
    endcase
    trial = {rem, quo[63]};
    qbit  = (trial >= {1'b0, op_b[31:0]});
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    case (state)
      A_IDLE: begin
        if (cmd.start) begin
          op_a   <= a;
          op_b   <= b;
          cnt    <= '0;
          acc    <= '0;
          pp_vld <= 1'b0;
          rem    <= '0;
          quo    <= a;
          state  <= (cmd.op == abtf_pkg::ALU_DIV) ? A_DIV : A_MUL;
        end
      end
      A_MUL: begin
        if (cnt < 7'd4) begin
          pp     <= 64'(half_a) * 64'(half_b);
          pp_sh  <= 2'({1'b0, cnt[1]} + {1'b0, cnt[0]});
          pp_vld <= 1'b1;
          cnt    <= cnt + 7'd1;
        end else begin
          pp_vld <= 1'b0;
        end
        if (pp_vld) begin
          acc <= acc + pp_ext;
          if (cnt == 7'd4) begin
            done  <= 1'b1;
            state <= A_IDLE;
          end
        end
      end
      A_DIV: begin
        rem <= qbit ? 32'(trial - {1'b0, op_b[31:0]}) : trial[31:0];
        quo <= {quo[62:0], qbit};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          acc   <= {64'b0, quo[62:0], qbit};
          done  <= 1'b1;
          state <= A_IDLE;
        end
      end
      default: state <= A_IDLE;
    endcase
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end
  end

endmodule

### rtl/abtf_table.sv
// track table memory, one write port and one registered read port
`timescale 1ns / 1ps
module abtf_table #(
  parameter int ENTRIES = 1,
  parameter int IW      = 1
) (
  input  logic               clk,
  input  logic [IW-1:0]      rd_addr,
  output abtf_pkg::entry_t   rd_data,
  input  logic               wr_en,
  input  logic [IW-1:0]      wr_addr,
  input  abtf_pkg::entry_t   wr_data
);

  abtf_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/alpha_beta_track_filter.sv
// alpha-beta track table: key scan, sequencer and filter datapath around a shared mul/div unit
// a bad id goes straight to the result; otherwise a key scan of the tracks in the table, then
// a create, overwrite, stale or full result, or a filter update
// filter time is set by the shared unit: six multiplies and two divides per axis
// one observation at a time; a new one is taken once the result enters the output register
// reset clears the fill count and so empties the table at once; no clearing pass
`timescale 1ns / 1ps
module alpha_beta_track_filter #(
  parameter int TRACK_ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             obs_valid,
  output logic             obs_stall,
  input  abtf_pkg::obs_t   obs_data,
  output logic             res_valid,
  input  logic             res_stall,
  output abtf_pkg::res_t   res_data
);

  localparam int IW = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
  localparam int CW = $clog2(TRACK_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TRACK_ENTRIES);
  localparam logic signed [63:0] LIM64 = 64'sh0000_00FF_FFFF_FFFF;

  typedef enum logic [21:0] {
    S_IDLE   = 22'h000001,
    S_SEARCH = 22'h000002,
    S_DECIDE = 22'h000004,
    S_INIT   = 22'h000008,
    S_D2     = 22'h000010,
    S_AXIS   = 22'h000020,
    S_T1     = 22'h000040,
    S_T2     = 22'h000080,
    S_PRED   = 22'h000100,
    S_RES    = 22'h000200,
    S_RA     = 22'h000400,
    S_RB     = 22'h000800,
    S_DV1    = 22'h001000,
    S_CV     = 22'h002000,
    S_M1     = 22'h004000,
    S_M2     = 22'h008000,
    S_NV     = 22'h010000,
    S_DIFF   = 22'h020000,
    S_DV2    = 22'h040000,
    S_FIN    = 22'h080000,
    S_WRITE  = 22'h100000,
    S_EMIT   = 22'h200000
  } state_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    mag64 = x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] apply_sign(input logic neg, input logic [63:0] m);
    apply_sign = neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] sat_mag(input logic [127:0] x);
    sat_mag = (x > 128'(abtf_pkg::WIDE_LIM)) ? 64'(abtf_pkg::WIDE_LIM) : x[63:0];
  endfunction

  function automatic logic signed [41:0] sat_lim(input logic signed [63:0] x);
    if (x > LIM64) sat_lim = 42'(LIM64);
    else if (x < -LIM64) sat_lim = 42'(-LIM64);
    else sat_lim = x[41:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sh0000_0000_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = x[31:0];
  endfunction

  function automatic logic [15:0] gain(input logic [15:0] base, input logic [15:0] slope,
                                       input logic [15:0] c);
    logic [31:0] pr;
    pr   = 32'(slope) * 32'(c);
    gain = base + 16'(pr >> 15);
  endfunction

  state_t                  state;
  abtf_pkg::obs_t          item;
  logic [15:0]             c_q;
  logic [CW-1:0]           fill;
  logic [CW-1:0]           scan;
  logic [IW-1:0]           last;
  logic                    pend;
  logic                    found;
  logic [IW-1:0]           idx;
  abtf_pkg::entry_t        row;
  abtf_pkg::entry_t        rd_data;
  logic [2:0]              status;
  logic [31:0]             d;
  logic [63:0]             d2;
  logic [15:0]             alpha;
  logic [15:0]             beta;
  logic [15:0]             vw;
  logic [1:0]              k;
  logic signed [31:0]      v_old;
  logic signed [41:0]      t1;
  logic signed [41:0]      t2;
  logic signed [41:0]      pred;
  logic signed [42:0]      r;
  logic signed [41:0]      cv;
  logic signed [63:0]      s1;
  logic signed [63:0]      sum;
  logic                    dif_neg;
  abtf_pkg::alu_cmd_t      alu_cmd;
  logic [63:0]             alu_a;
  logic [63:0]             alu_b;
  logic                    alu_done;
  logic [127:0]            alu_res;
  abtf_pkg::res_t          res_next;

  logic [15:0]             c_in;
  logic                    bad_in;
  logic signed [31:0]      mp_k;
  logic signed [31:0]      mv_k;
  logic signed [31:0]      p_k;
  logic signed [31:0]      a_k;
  logic signed [31:0]      nv_k;
  logic signed [63:0]      r_comb;
  logic signed [32:0]      dif;
  logic [31:0]             d_comb;
  logic [31:0]             nc_sum;
  logic [31:0]             nc;

  assign obs_stall = (state != S_IDLE);

  always_comb begin
    c_in   = (obs_data.meas_confidence > abtf_pkg::CONF_ONE) ? abtf_pkg::CONF_ONE
                                                            : obs_data.meas_confidence;
    bad_in = (obs_data.observer_id == 16'd0) || (obs_data.target_id == 16'd0) ||
             (obs_data.observer_id == obs_data.target_id);
    case (k)
      2'd0: begin
        mp_k = item.meas_pos_x;
        mv_k = item.meas_vel_x;
      end
      2'd1: begin
        mp_k = item.meas_pos_y;
        mv_k = item.meas_vel_y;
      end
      default: begin
        mp_k = item.meas_pos_z;
        mv_k = item.meas_vel_z;
      end
    endcase
    p_k    = $signed(row.pos[k]);
    a_k    = $signed(row.acc[k]);
    nv_k   = $signed(row.vel[k]);
    r_comb = 64'(mp_k) - 64'(pred);
    dif    = 33'(nv_k) - 33'(v_old);
    d_comb = item.obs_time - row.time_tag;
    nc_sum = 32'(abtf_pkg::CONF_KEEP) * 32'(row.conf) + 32'(abtf_pkg::CONF_NEW) * 32'(c_q);
    nc     = ((nc_sum >> 15) > 32'(abtf_pkg::CONF_ONE)) ? 32'(abtf_pkg::CONF_ONE)
                                                        : (nc_sum >> 15);
  end

  always_comb begin
    res_next        = '0;
    res_next.status = status;
    if (!(status inside {abtf_pkg::ST_BAD_ID, abtf_pkg::ST_STALE, abtf_pkg::ST_FULL})) begin
      res_next.est_pos_x      = $signed(row.pos[0]);
      res_next.est_pos_y      = $signed(row.pos[1]);
      res_next.est_pos_z      = $signed(row.pos[2]);
      res_next.est_vel_x      = $signed(row.vel[0]);
      res_next.est_vel_y      = $signed(row.vel[1]);
      res_next.est_vel_z      = $signed(row.vel[2]);
      res_next.est_confidence = row.conf;
      res_next.update_count   = row.count;
    end
  end

  abtf_table #(
    .ENTRIES (TRACK_ENTRIES),
    .IW      (IW)
  ) u_table (
    .clk     (clk),
    .rd_addr (scan[IW-1:0]),
    .rd_data (rd_data),
    .wr_en   (state == S_WRITE),
    .wr_addr (idx),
    .wr_data (row)
  );

  abtf_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (alu_cmd),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    alu_cmd.start <= 1'b0;
    if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (obs_valid) begin
          item <= obs_data;
          c_q  <= c_in;
          scan <= '0;
          pend <= 1'b0;
          found <= 1'b0;
          if (bad_in) begin
            status <= abtf_pkg::ST_BAD_ID;
            state  <= S_EMIT;
          end else if (fill == '0) begin
            state <= S_DECIDE;
          end else begin
            state <= S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (pend && rd_data.key == {item.observer_id, item.target_id}) begin
          found <= 1'b1;
          idx   <= last;
          row   <= rd_data;
          state <= S_DECIDE;
        end else if (pend && CW'(last) == fill - CW'(1)) begin
          state <= S_DECIDE;
        end
        pend <= 1'b1;
        last <= scan[IW-1:0];
        scan <= scan + CW'(1);
      end
      S_DECIDE: begin
        if (!found) begin
          if (fill == FULL_CNT) begin
            status <= abtf_pkg::ST_FULL;
            state  <= S_EMIT;
          end else begin
            idx          <= fill[IW-1:0];
            fill         <= fill + CW'(1);
            row.key      <= {item.observer_id, item.target_id};
            row.time_tag <= item.obs_time;
            row.pos      <= {item.meas_pos_z, item.meas_pos_y, item.meas_pos_x};
            row.vel      <= {item.meas_vel_z, item.meas_vel_y, item.meas_vel_x};
            row.acc      <= '0;
            row.conf     <= c_q;
            row.count    <= 16'd1;
            status       <= abtf_pkg::ST_CREATED;
            state        <= S_WRITE;
          end
        end else if (item.obs_time < row.time_tag) begin
          status <= abtf_pkg::ST_STALE;
          state  <= S_EMIT;
        end else if (item.obs_time == row.time_tag) begin
          row.pos <= {item.meas_pos_z, item.meas_pos_y, item.meas_pos_x};
          row.vel <= {item.meas_vel_z, item.meas_vel_y, item.meas_vel_x};
          if (c_q > row.conf) begin
            row.conf <= c_q;
          end
          if (row.count != 16'hFFFF) begin
            row.count <= row.count + 16'd1;
          end
          status <= abtf_pkg::ST_SAME;
          state  <= S_WRITE;
        end else begin
          state <= S_INIT;
        end
      end
      S_INIT: begin
        d       <= d_comb;
        alpha   <= gain(abtf_pkg::ALPHA_BASE, abtf_pkg::ALPHA_SLOPE, c_q);
        beta    <= gain(abtf_pkg::BETA_BASE, abtf_pkg::BETA_SLOPE, c_q);
        vw      <= gain(abtf_pkg::VW_BASE, abtf_pkg::VW_SLOPE, c_q);
        alu_cmd <= '{start: 1'b1, op: abtf_pkg::ALU_MUL};
        alu_a   <= 64'(d_comb);
        alu_b   <= 64'(d_comb);
        state   <= S_D2;
      end
      S_D2: begin
        if (alu_done) begin
          d2    <= alu_res[63:0];
          k     <= 2'd0;
          state <= S_AXIS;
        end
      end
      S_AXIS: begin
        v_old   <= nv_k;
        alu_cmd <= '{start: 1'b1, op: abtf_pkg::ALU_MUL};
        alu_a   <= mag64(64'(nv_k));
        alu_b   <= 64'(d);
        state   <= S_T1;
      end
      S_T1: begin
        if (alu_done) begin
          t1      <= 42'(apply_sign(v_old[31], sat_mag(alu_res >> 18)));
          alu_cmd <= '{start: 1'b1, op: abtf_pkg::ALU_MUL};
          alu_a   <= mag64(64'(a_k));
          alu_b   <= d2;
          state   <= S_T2;
        end
      end
      S_T2: begin
        if (alu_done) begin
          t2    <= 42'(apply_sign(a_k[31], sat_mag(alu_res >> 29)));
          state <= S_PRED;
        end
      end
      S_PRED: begin
        pred  <= sat_lim(64'(p_k) + 64'(t1) + 64'(t2));
        state <= S_RES;
      end
      S_RES: begin
        r       <= 43'(r_comb);
        alu_cmd <= '{start: 1'b1, op: abtf_pkg::ALU_MUL};
        alu_a   <= mag64(r_comb);
        alu_b   <= 64'(alpha);
        state   <= S_RA;
      end
      S_RA: begin
        if (alu_done) begin
          row.pos[k] <= sat32(64'(pred) + apply_sign(r[42], {16'b0, alu_res[63:16]}));
          alu_cmd    <= '{start: 1'b1, op: abtf_pkg::ALU_MUL};
          alu_a      <= mag64(64'(r));
          alu_b      <= {46'b0, beta, 2'b00};
          state      <= S_RB;
        end
      end
      S_RB: begin
        if (alu_done) begin
          alu_cmd <= '{start: 1'b1, op: abtf_pkg::ALU_DIV};
          alu_a   <= alu_res[63:0];
          alu_b   <= 64'(d);
          state   <= S_DV1;
        end
      end
      S_DV1: begin
        if (alu_done) begin
          cv    <= sat_lim(64'(v_old) + apply_sign(r[42], alu_res[63:0]));
          state <= S_CV;
        end
      end
      S_CV: begin
        alu_cmd <= '{start: 1'b1, op: abtf_pkg::ALU_MUL};
        alu_a   <= mag64(64'(cv));
        alu_b   <= 64'(17'h10000 - 17'(vw));
        state   <= S_M1;
      end
      S_M1: begin
        if (alu_done) begin
          s1      <= apply_sign(cv[41], alu_res[63:0]);
          alu_cmd <= '{start: 1'b1, op: abtf_pkg::ALU_MUL};
          alu_a   <= mag64(64'(mv_k));
          alu_b   <= 64'(vw);
          state   <= S_M2;
        end
      end
      S_M2: begin
        if (alu_done) begin
          sum   <= s1 + apply_sign(mv_k[31], alu_res[63:0]);
          state <= S_NV;
        end
      end
      S_NV: begin
        row.vel[k] <= sat32(apply_sign(sum[63], mag64(sum) >> 16));
        state      <= S_DIFF;
      end
      S_DIFF: begin
        dif_neg <= dif[32];
        alu_cmd <= '{start: 1'b1, op: abtf_pkg::ALU_DIV};
        alu_a   <= mag64(64'(dif)) << 10;
        alu_b   <= 64'(d);
        state   <= S_DV2;
      end
      S_DV2: begin
        if (alu_done) begin
          row.acc[k] <= sat32(apply_sign(dif_neg, alu_res[63:0]));
          if (k == 2'd2) begin
            state <= S_FIN;
          end else begin
            k     <= k + 2'd1;
            state <= S_AXIS;
          end
        end
      end
      S_FIN: begin
        row.conf     <= nc[15:0];
        row.time_tag <= item.obs_time;
        if (row.count != 16'hFFFF) begin
          row.count <= row.count + 16'd1;
        end
        status <= abtf_pkg::ST_FILTERED;
        state  <= S_WRITE;
      end
      S_WRITE: begin
        state <= S_EMIT;
      end
      S_EMIT: begin
        if (!res_valid || !res_stall) begin
          res_valid <= 1'b1;
          res_data  <= res_next;
          state     <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state         <= S_IDLE;
      fill          <= '0;
      res_valid     <= 1'b0;
      alu_cmd.start <= 1'b0;
    end
  end

endmodule

### rtl/abtf_checker.sv
// port checker for the alpha-beta track filter and its bind
`timescale 1ns / 1ps
module abtf_checker (
  input logic           clk,
  input logic           rst,
  input logic           obs_valid,
  input logic           obs_stall,
  input abtf_pkg::obs_t obs_data,
  input logic           res_valid,
  input logic           res_stall,
  input abtf_pkg::res_t res_data
);

  logic obs_take;
  assign obs_take = obs_valid && !obs_stall && (obs_data.observer_id == obs_data.observer_id);

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    obs_take |=> obs_stall)
    else $error("block took a request without going busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.status == abtf_pkg::ST_BAD_ID ||
                  res_data.status == abtf_pkg::ST_STALE ||
                  res_data.status == abtf_pkg::ST_FULL)
    |-> res_data.est_pos_x == 0 && res_data.est_pos_y == 0 && res_data.est_pos_z == 0 &&
        res_data.est_vel_x == 0 && res_data.est_vel_y == 0 && res_data.est_vel_z == 0 &&
        res_data.est_confidence == 0 && res_data.update_count == 0)
    else $error("rejected request carries track data");

  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.est_confidence <= abtf_pkg::CONF_ONE)
    else $error("confidence above one");

endmodule

bind alpha_beta_track_filter abtf_checker u_abtf_checker (.*);
